>>> src/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg: shared types and helpers for the slot bitmap allocator
// Field widths, operation codes, the token that walks the cell chain and
// the per-word bit-count and highest-bit helpers used inside each cell.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int FUNC_W   = 2;
  localparam int AMOUNT_W = 11;
  localparam int SLOT_W   = 10;
  localparam int OUT_W    = 11;

  // one cell holds one bitmap word
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam int PCNT_W = 6;

  // running counts in the token, wide enough for the largest slot count
  localparam int CNT_W = 17;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC    = 2'd0,
    FUNC_FREE     = 2'd1,
    FUNC_FREE_ALL = 2'd2,
    FUNC_RELEASE  = 2'd3
  } func_t;

  // operation broadcast from the controller to every cell
  typedef struct packed {
    func_t             func;
    logic              up;
    logic              rel_en;
    logic [SLOT_W-1:0] rel_slot;
  } ctl_t;

  // token handed from cell to cell during a sweep
  typedef struct packed {
    logic             vld;
    logic             found;
    logic [CNT_W-1:0] rem;
    logic [CNT_W-1:0] done;
    logic [CNT_W-1:0] mark;
  } tok_t;

  typedef logic [WORD_W-1:0][PCNT_W-1:0] pcnt_vec_t;

  // inclusive prefix bit counts, log-depth scan
  function automatic pcnt_vec_t prefix_count(input logic [WORD_W-1:0] v);
    pcnt_vec_t p;
    for (int j = 0; j < WORD_W; j++) begin
      p[j] = PCNT_W'(v[j]);
    end
    for (int lvl = 0; lvl < BIT_W; lvl++) begin
      for (int j = WORD_W - 1; j >= 0; j--) begin
        if (j >= (1 << lvl)) begin
          p[j] = p[j] + p[j - (1 << lvl)];
        end
      end
    end
    return p;
  endfunction

  // position of the highest set bit, zero for an empty word
  function automatic logic [BIT_W-1:0] msb_pos(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (v[j]) begin
        pos = BIT_W'(j);
      end
    end
    return pos;
  endfunction

endpackage

>>> src/sba_if.sv
// ----------------------------------------------------------------------------
// sba_if: request and response channels of the slot bitmap allocator
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface sba_in_if;
  import sba_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [AMOUNT_W-1:0] amount;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, func, amount, slot, input ready);
  modport sink   (input valid, func, amount, slot, output ready);
endinterface

interface sba_out_if;
  import sba_pkg::*;

  logic             valid;
  logic             ready;
  logic             accepted;
  logic [OUT_W-1:0] done_count;
  logic [OUT_W-1:0] high_mark;
  logic [OUT_W-1:0] live_count;

  modport source (output valid, accepted, done_count, high_mark, live_count, input ready);
  modport sink   (input valid, accepted, done_count, high_mark, live_count, output ready);
endinterface

>>> src/slot_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// slot_bitmap_allocator_top: occupancy bitmap allocator with live count
// Allocate, free-from-top, free-all and release-one on a bitmap of SLOTS
// slots, one response transaction per request transaction.
// ----------------------------------------------------------------------------
// The bitmap is split into 32-bit words, one per cell, chained in a row.
// Every accepted request launches a token that walks the whole chain, one
// cell per clock: upward from the lowest word for allocate, downward from
// the top word for the other operations. Each cell applies the operation to
// its word while the token sits there and adds its share to the running
// counts and the high mark carried by the token. The time a request takes
// until its response is valid is set by the length of the chain; a refused
// allocation answers in the cycle after it is taken, with no sweep. One
// request is in flight at a time and the next one is taken once the response
// transaction completes. The bitmap is clear after reset with no clearing
// pass. Result fields keep their low 11 bits.
// ----------------------------------------------------------------------------
module slot_bitmap_allocator_top #(
  parameter int SLOTS = 1024
) (
  input  logic   clk,
  input  logic   rst_n,
  sba_in_if.sink   in_chan,
  sba_out_if.source out_chan
);
  import sba_pkg::*;

  localparam int NWORDS    = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int LAST_BITS = SLOTS - (NWORDS - 1) * WORD_W;
  localparam int CW        = $clog2(SLOTS + 1);
  localparam int SUM_W     = ((CW > AMOUNT_W) ? CW : AMOUNT_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_RESP
  } state_t;

  state_t           state_r, state_nxt;
  ctl_t             ctl_r, ctl_nxt;
  tok_t             inj_r, inj_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic [CW-1:0]    mark_r, mark_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             out_acc_r, out_acc_nxt;
  logic [OUT_W-1:0] out_done_r, out_done_nxt;
  logic [OUT_W-1:0] out_mark_r, out_mark_nxt;
  logic [OUT_W-1:0] out_live_r, out_live_nxt;

  tok_t tok_in  [NWORDS];
  tok_t tok_out [NWORDS];
  tok_t end_tok;

  func_t          req_func;
  logic           refuse;
  logic [CW-1:0]  sweep_used;

  // cell chain; the token enters at the end chosen by the sweep direction
  for (genvar g = 0; g < NWORDS; g++) begin : g_cell
    if (NWORDS == 1) begin : g_only
      assign tok_in[g] = inj_r;
    end else if (g == 0) begin : g_low
      assign tok_in[g] = ctl_r.up ? inj_r : tok_out[g+1];
    end else if (g == NWORDS - 1) begin : g_high
      assign tok_in[g] = ctl_r.up ? tok_out[g-1] : inj_r;
    end else begin : g_mid
      assign tok_in[g] = ctl_r.up ? tok_out[g-1] : tok_out[g+1];
    end

    sba_cell #(
      .IDX        (g),
      .VALID_BITS ((g == NWORDS - 1) ? LAST_BITS : WORD_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl_r),
      .tok_i (tok_in[g]),
      .tok_o (tok_out[g])
    );
  end

  // the token leaves the chain at the opposite end
  assign end_tok = ctl_r.up ? tok_out[NWORDS-1] : tok_out[0];

  assign req_func = func_t'(in_chan.func);
  // allocation that does not fit is refused without touching the map
  assign refuse   = (req_func == FUNC_ALLOC) &&
                    ((SUM_W'(used_r) + SUM_W'(in_chan.amount)) > SUM_W'(SLOTS));
  assign sweep_used = (ctl_r.func == FUNC_ALLOC) ? used_r + CW'(end_tok.done)
                                                 : used_r - CW'(end_tok.done);

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign out_chan.valid      = out_vld_r;
  assign out_chan.accepted   = out_acc_r;
  assign out_chan.done_count = out_done_r;
  assign out_chan.high_mark  = out_mark_r;
  assign out_chan.live_count = out_live_r;

  always_comb begin
    state_nxt    = state_r;
    ctl_nxt      = ctl_r;
    inj_nxt      = inj_r;
    inj_nxt.vld  = 1'b0;
    used_nxt     = used_r;
    mark_nxt     = mark_r;
    out_vld_nxt  = out_vld_r;
    out_acc_nxt  = out_acc_r;
    out_done_nxt = out_done_r;
    out_mark_nxt = out_mark_r;
    out_live_nxt = out_live_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          if (refuse) begin
            out_vld_nxt  = 1'b1;
            out_acc_nxt  = 1'b0;
            out_done_nxt = '0;
            out_mark_nxt = OUT_W'(mark_r);
            out_live_nxt = OUT_W'(used_r);
            state_nxt    = ST_RESP;
          end else begin
            ctl_nxt.func     = req_func;
            ctl_nxt.up       = (req_func == FUNC_ALLOC);
            ctl_nxt.rel_en   = (req_func == FUNC_RELEASE) &&
                               (32'(in_chan.slot) < SLOTS);
            ctl_nxt.rel_slot = in_chan.slot;
            inj_nxt.vld      = 1'b1;
            inj_nxt.found    = 1'b0;
            inj_nxt.done     = '0;
            inj_nxt.mark     = '0;
            unique case (req_func) inside
              FUNC_ALLOC, FUNC_FREE: inj_nxt.rem = CNT_W'(in_chan.amount);
              FUNC_FREE_ALL:         inj_nxt.rem = CNT_W'(SLOTS);
              default:               inj_nxt.rem = '0;
            endcase
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        // token back out of the chain: totals are final
        if (end_tok.vld) begin
          used_nxt     = sweep_used;
          mark_nxt     = CW'(end_tok.mark);
          out_vld_nxt  = 1'b1;
          out_acc_nxt  = 1'b1;
          out_done_nxt = OUT_W'(end_tok.done);
          out_mark_nxt = OUT_W'(end_tok.mark);
          out_live_nxt = OUT_W'(sweep_used);
          state_nxt    = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_chan.ready) begin
          out_vld_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ctl_r      <= '0;
      inj_r      <= '0;
      used_r     <= '0;
      mark_r     <= '0;
      out_vld_r  <= 1'b0;
      out_acc_r  <= 1'b0;
      out_done_r <= '0;
      out_mark_r <= '0;
      out_live_r <= '0;
    end else begin
      state_r    <= state_nxt;
      ctl_r      <= ctl_nxt;
      inj_r      <= inj_nxt;
      used_r     <= used_nxt;
      mark_r     <= mark_nxt;
      out_vld_r  <= out_vld_nxt;
      out_acc_r  <= out_acc_nxt;
      out_done_r <= out_done_nxt;
      out_mark_r <= out_mark_nxt;
      out_live_r <= out_live_nxt;
    end
  end

endmodule

>>> src/sba_cell.sv
// ----------------------------------------------------------------------------
// sba_cell: one bitmap word of the allocator chain
// Holds one word, applies the broadcast operation when the token sits here
// and hands the updated token to the neighbor on the next clock.
// ----------------------------------------------------------------------------
module sba_cell #(
  parameter int IDX        = 0,
  parameter int VALID_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sba_pkg::ctl_t ctl,
  input  sba_pkg::tok_t tok_i,
  output sba_pkg::tok_t tok_o
);
  import sba_pkg::*;

  localparam logic [WORD_W-1:0] VMASK = (VALID_BITS >= WORD_W) ? {WORD_W{1'b1}} :
                                        ((WORD_W'(1) << VALID_BITS) - WORD_W'(1));
  localparam logic [CNT_W-1:0] BASE = CNT_W'(IDX * WORD_W);

  logic [WORD_W-1:0] word_r, word_nxt;
  tok_t              tok_r;

  logic [WORD_W-1:0] free_v, occ_v, occ_rev, set_v, clr_v, new_w;
  pcnt_vec_t         pf, ps;
  logic [PCNT_W-1:0] rem_c, n;
  logic              hit;
  logic [BIT_W-1:0]  rel_bit;
  logic [CNT_W-1:0]  cand;

  always_comb begin
    free_v = ~word_r & VMASK;
    occ_v  = word_r & VMASK;
    for (int j = 0; j < WORD_W; j++) begin
      occ_rev[j] = occ_v[WORD_W-1-j];
    end
    pf = prefix_count(free_v);
    ps = prefix_count(occ_rev);

    // more than a word's worth left behaves like a full word here
    rem_c = (tok_r.rem > CNT_W'(WORD_W)) ? PCNT_W'(WORD_W) : tok_r.rem[PCNT_W-1:0];

    for (int j = 0; j < WORD_W; j++) begin
      set_v[j] = free_v[j] && (pf[j] <= rem_c);
      clr_v[j] = occ_v[j] && (ps[WORD_W-1-j] <= rem_c);
    end

    rel_bit = ctl.rel_slot[BIT_W-1:0];
    hit     = ctl.rel_en && (int'(ctl.rel_slot[SLOT_W-1:BIT_W]) == IDX);

    new_w = word_r;
    n     = '0;
    tok_o = tok_r;
    unique case (ctl.func) inside
      FUNC_ALLOC: begin
        new_w = word_r | set_v;
        n     = (pf[WORD_W-1] < rem_c) ? pf[WORD_W-1] : rem_c;
        tok_o.rem = tok_r.rem - CNT_W'(n);
      end
      FUNC_FREE, FUNC_FREE_ALL: begin
        new_w = word_r & ~clr_v;
        n     = (ps[WORD_W-1] < rem_c) ? ps[WORD_W-1] : rem_c;
        tok_o.rem = tok_r.rem - CNT_W'(n);
      end
      FUNC_RELEASE: begin
        if (hit && word_r[rel_bit]) begin
          new_w          = word_r;
          new_w[rel_bit] = 1'b0;
          n              = PCNT_W'(1);
        end
      end
    endcase
    tok_o.done = tok_r.done + CNT_W'(n);

    // high mark: upward sweep keeps the last nonzero word, downward the first
    cand = BASE + CNT_W'(msb_pos(new_w)) + CNT_W'(1);
    if (ctl.up) begin
      if (|new_w) begin
        tok_o.mark = cand;
      end
    end else begin
      if (!tok_r.found && (|new_w)) begin
        tok_o.mark  = cand;
        tok_o.found = 1'b1;
      end
    end

    word_nxt = tok_r.vld ? new_w : word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
      tok_r  <= '0;
    end else begin
      word_r <= word_nxt;
      tok_r  <= tok_i;
    end
  end

endmodule
